// ===== hdl/bale_pkg.sv =====
package bale_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int POS_W          = 5;
  localparam int STAT_W         = 2;
  localparam int TOTAL_W        = 5;
  localparam int OP_W           = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
  localparam logic [OP_W-1:0] OP_SORTED = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } bale_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] found_value;
    logic [TOTAL_W-1:0]       entry_total;
  } bale_out_t;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_INSERT,
    ACT_DELETE,
    ACT_LOAD,
    ACT_LOCATE,
    ACT_SORT
  } bale_act_t;

  typedef struct packed {
    bale_act_t                act;
    logic                     commit;
    logic signed [DATA_W-1:0] val;
  } bale_ctl_t;

  typedef struct packed {
    logic tok;
    logic hit;
  } bale_link_t;

endpackage

// ===== hdl/bale_cell.sv =====
module bale_cell import bale_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int IDX        = 0,
  parameter int CMP_W      = POS_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bale_ctl_t                ctl,
  input  logic [CMP_W-1:0]         pos,
  input  logic [CMP_W-1:0]         cnt,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  input  bale_link_t               link_in,
  output bale_link_t               link_out,
  output logic signed [DATA_W-1:0] entry,
  output logic                     stop,
  output logic                     found
);

  localparam logic [CMP_W-1:0] IDX_V = CMP_W'(IDX);
  localparam logic             LAST  = (IDX == LIST_DEPTH - 1);

  logic signed [DATA_W-1:0] entry_r, entry_nxt;
  logic                     tok_r, tok_nxt;
  logic                     hit_r, hit_nxt;
  logic                     passed_r, passed_nxt;
  logic                     live, eq, ge, hit_here, scanning;

  assign live     = IDX_V < cnt;
  assign eq       = entry_r == ctl.val;
  assign ge       = entry_r >= ctl.val;
  assign scanning = (ctl.act == ACT_LOCATE) || (ctl.act == ACT_SORT);
  assign stop     = scanning && tok_r &&
                    (!live || ((ctl.act == ACT_SORT) && ge) ||
                     (LAST && (ctl.act == ACT_LOCATE)));
  assign hit_here = tok_r && (hit_r || (live && eq));
  assign found    = stop && hit_here;
  assign link_out = '{tok: scanning && tok_r && !stop, hit: hit_here};
  assign entry    = entry_r;

  always_comb begin
    entry_nxt  = entry_r;
    tok_nxt    = 1'b0;
    hit_nxt    = 1'b0;
    passed_nxt = passed_r;
    case (ctl.act)
      ACT_INSERT: begin
        if (IDX_V == pos) begin
          entry_nxt = ctl.val;
        end else if (IDX_V > pos) begin
          entry_nxt = left_entry;
        end
      end
      ACT_DELETE: begin
        if (IDX_V >= pos) begin
          entry_nxt = right_entry;
        end
      end
      ACT_LOAD: begin
        tok_nxt    = (IDX == 0);
        passed_nxt = 1'b0;
      end
      ACT_LOCATE, ACT_SORT: begin
        tok_nxt    = link_in.tok;
        hit_nxt    = link_in.hit;
        passed_nxt = passed_r || (tok_r && !stop);
        if ((ctl.act == ACT_SORT) && ctl.commit) begin
          if (stop) begin
            entry_nxt = ctl.val;
          end else if (!passed_r && !tok_r) begin
            entry_nxt = left_entry;
          end
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= 1'b0;
      hit_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      hit_r    <= hit_nxt;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hdl/bounded_array_list_engine.sv =====
// Positional insert, delete and every rejected word finish at the accepting edge; the result
// strobe follows in the next cycle, and busy stays low, so one such word is taken per cycle.
// Locate and sorted insert pass a token down the cell row one cell per cycle, with busy high,
// so no new word is taken until the cell where the scan stops has ended it.
// Synchronous active-low reset empties the list and clears the token; the receiver cannot
// stall, so each result strobe is high for exactly one cycle.
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bale_in_t  in_data,
  output logic      out_strobe,
  output bale_out_t out_data
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  bale_out_t                out_r, out_nxt;

  logic                     accept, any_stop, any_found;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  bale_ctl_t                ctl;
  logic [LIST_DEPTH-1:0]    stop_vec, found_vec;
  logic signed [DATA_W-1:0] ent [LIST_DEPTH];
  bale_link_t               link [LIST_DEPTH+1];

  assign busy       = state_r == S_SCAN;
  assign accept     = start && !busy;
  assign pos_ext    = CMP_W'(in_data.position);
  assign cnt_ext    = CMP_W'(cnt_r);
  assign any_stop   = |stop_vec;
  assign any_found  = |found_vec;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
  assign link[0]    = '{tok: 1'b0, hit: 1'b0};

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = ent[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = ent[i+1];
    end
    bale_cell #(
      .LIST_DEPTH(LIST_DEPTH),
      .IDX       (i),
      .CMP_W     (CMP_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .pos        (pos_ext),
      .cnt        (cnt_ext),
      .left_entry (left_e),
      .right_entry(right_e),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .entry      (ent[i]),
      .stop       (stop_vec[i]),
      .found      (found_vec[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ctl            = '{act: ACT_IDLE, commit: 1'b0, val: in_data.value};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt = '{status: ST_DONE, found_value: '0, entry_total: TOTAL_W'(cnt_r)};
          case (in_data.op)
            OP_INSERT: begin
              out_strobe_nxt = 1'b1;
              if ((cnt_r == FULL) || (pos_ext > cnt_ext)) begin
                out_nxt.status = ST_REJECT;
              end else begin
                ctl.act             = ACT_INSERT;
                cnt_nxt             = cnt_r + 1'b1;
                out_nxt.entry_total = TOTAL_W'(cnt_nxt);
              end
            end
            OP_DELETE: begin
              out_strobe_nxt = 1'b1;
              if (pos_ext >= cnt_ext) begin
                out_nxt.status = ST_REJECT;
              end else begin
                ctl.act             = ACT_DELETE;
                cnt_nxt             = cnt_r - 1'b1;
                out_nxt.entry_total = TOTAL_W'(cnt_nxt);
              end
            end
            OP_SORTED: begin
              if (cnt_r == FULL) begin
                out_strobe_nxt = 1'b1;
                out_nxt.status = ST_REJECT;
              end else begin
                ctl.act   = ACT_LOAD;
                op_nxt    = in_data.op;
                key_nxt   = in_data.value;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              ctl.act   = ACT_LOAD;
              op_nxt    = in_data.op;
              key_nxt   = in_data.value;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.val = key_r;
        ctl.act = (op_r == OP_SORTED) ? ACT_SORT : ACT_LOCATE;
        if (any_stop) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          if (op_r == OP_SORTED) begin
            ctl.commit = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            out_nxt    = '{status: ST_DONE, found_value: '0,
                           entry_total: TOTAL_W'(cnt_nxt)};
          end else if (any_found) begin
            out_nxt = '{status: ST_DONE, found_value: key_r,
                        entry_total: TOTAL_W'(cnt_r)};
          end else begin
            out_nxt = '{status: ST_NOT_FOUND, found_value: '1,
                        entry_total: TOTAL_W'(cnt_r)};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe while a scan is still running");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("live count exceeds list depth");

  a_single_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stop_vec))
    else $error("more than one cell ended the scan");

  a_positional_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_data.op == OP_INSERT) || (in_data.op == OP_DELETE))) |=> out_strobe_r)
    else $error("positional word produced no result");

  a_stop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (|stop_vec) |-> (state_r == S_SCAN))
    else $error("cell stopped outside a scan");

endmodule
